FILE: rtl/ttpg_pkg.sv
`timescale 1ns / 1ps

package ttpg_pkg;

    localparam int PIX_W = 9;   // screen coordinate width
    localparam int DIV_W = 6;   // divisor / remainder width (values up to 63)
    localparam int CNT_W = 4;   // divider step counter

    localparam logic [7:0] FALLBACK_CHAR = 8'd63;   // '?'
    localparam logic [2:0] LEFT_BIT      = 3'd7;

    localparam logic [2:0] ACT_WRITE_CELL = 3'd0;
    localparam logic [2:0] ACT_SET_CURSOR = 3'd1;
    localparam logic [2:0] ACT_CURSOR_VIS = 3'd2;
    localparam logic [2:0] ACT_LOAD_GLYPH = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;
    localparam logic [2:0] ACT_PIXEL      = 3'd5;

    localparam logic [1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_TILE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GRID_COLS   = 2'd2;
    localparam logic [1:0] CFG_GRID_ROWS   = 2'd3;

    typedef struct packed {
        logic [2:0]       action;
        logic [5:0]       tile_col;
        logic [4:0]       row_index;
        logic [7:0]       char_code;
        logic [7:0]       fg_color;
        logic [7:0]       bg_color;
        logic             invert;
        logic             transparent;
        logic             flag;
        logic [7:0]       glyph_bits;
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } item_t;

    typedef struct packed {
        logic       pixel_write;
        logic [7:0] pixel_color;
    } result_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] fg_color;
        logic [7:0] bg_color;
        logic       invert;
        logic       transparent;
    } cell_t;

    typedef struct packed {
        logic       we;
        logic [7:0] char_code;
        logic [4:0] row_index;
        logic [7:0] glyph_bits;
        logic       flag;
    } glyph_wr_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_DIV,
        S_TILE,
        S_GLYPH_C,
        S_GLYPH_T,
        S_EVAL
    } state_t;

endpackage

FILE: rtl/ttpg_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module ttpg_div
    import ttpg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [PIX_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [PIX_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder,
    output logic             done
);

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             done_reg, done_next;
    logic [PIX_W-1:0] dq_reg,   dq_next;
    logic [DIV_W-1:0] r_reg,    r_next;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial   = {r_reg, dq_reg[PIX_W-1]};
        ge      = trial >= {1'b0, dsr_reg};
        diff    = trial - {1'b0, dsr_reg};
        r_next  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dq_next = {dq_reg[PIX_W-2:0], ge};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(PIX_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            r_reg   <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            dq_reg <= dq_next;
            r_reg  <= r_next;
        end
    end

    assign quotient  = dq_reg;
    assign remainder = r_reg;
    assign done      = done_reg;

    a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (cnt_reg == '0) && $past(cnt_reg == CNT_W'(1)))
        else $error("divider finished without running all steps");

endmodule

FILE: rtl/ttpg_tile_ram.sv
`timescale 1ns / 1ps

// Tile map store. A zeroing sweep runs after reset and on each clear request.
module ttpg_tile_ram
    import ttpg_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int TA_W  = 11
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear_start,
    output logic            sweep_busy,
    input  logic            we,
    input  logic [TA_W-1:0] waddr,
    input  cell_t           wdata,
    input  logic            re,
    input  logic [TA_W-1:0] raddr,
    output cell_t           rdata
);

    cell_t           mem [DEPTH];
    cell_t           rdata_reg;
    logic            sweep_reg, sweep_next;
    logic [TA_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic            port_we;
    logic [TA_W-1:0] port_addr;
    cell_t           port_data;

    always_comb
    begin
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (clear_start)
        begin
            sweep_next     = 1'b1;
            sweep_cnt_next = '0;
        end
        else if (sweep_reg)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
            if (sweep_cnt_reg == TA_W'(DEPTH - 1))
            begin
                sweep_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    always_comb
    begin
        port_we   = sweep_reg || we;
        port_addr = sweep_reg ? sweep_cnt_reg : waddr;
        port_data = sweep_reg ? '0 : wdata;
    end

    always_ff @(posedge clk)
    begin
        if (port_we)
        begin
            mem[port_addr] <= port_data;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata      = rdata_reg;
    assign sweep_busy = sweep_reg;

    a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !(we || re))
        else $error("tile store accessed during zeroing sweep");

endmodule

FILE: rtl/ttpg_glyph_ram.sv
`timescale 1ns / 1ps

// Glyph bitmap store plus per-glyph present flags with fallback lookup.
module ttpg_glyph_ram
    import ttpg_pkg::*;
#(
    parameter int GLYPH_ROWS  = 16,
    parameter int GLYPH_COUNT = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  glyph_wr_t  wr,
    input  logic       rd_en,
    input  logic [7:0] query_char,
    input  logic [4:0] query_row,
    output logic       hit,
    output logic [7:0] rd_data
);

    localparam int GI_W  = $clog2(GLYPH_COUNT);
    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GA_W  = $clog2(DEPTH);

    logic [7:0]             mem [DEPTH];
    logic [7:0]             rd_data_reg;
    logic [GLYPH_COUNT-1:0] present_reg;
    logic                   wr_ok;
    logic [GA_W-1:0]        waddr;
    logic [GA_W-1:0]        raddr;
    logic                   hit_direct;
    logic                   hit_fallback;
    logic [7:0]             resolved_char;

    function automatic logic has_glyph(input logic [7:0] c,
                                       input logic [GLYPH_COUNT-1:0] p);
        return (32'(c) < GLYPH_COUNT) && p[c[GI_W-1:0]];
    endfunction

    always_comb
    begin
        wr_ok = wr.we && (32'(wr.row_index) < GLYPH_ROWS)
                && (32'(wr.char_code) < GLYPH_COUNT);
        waddr = GA_W'(wr.char_code) * GA_W'(GLYPH_ROWS) + GA_W'(wr.row_index);

        hit_direct    = has_glyph(query_char, present_reg);
        hit_fallback  = has_glyph(FALLBACK_CHAR, present_reg);
        resolved_char = hit_direct ? query_char : FALLBACK_CHAR;
        hit           = hit_direct || hit_fallback;
        raddr = GA_W'(resolved_char) * GA_W'(GLYPH_ROWS) + GA_W'(query_row);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else if (wr_ok)
        begin
            present_reg[wr.char_code[GI_W-1:0]] <= wr.flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[waddr] <= wr.glyph_bits;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/text_tile_pixel_generator_core.sv
`timescale 1ns / 1ps

// Channel   Ports                          Transaction
// input     start, busy, item              start && !busy at a rising edge
// result    done, result                   done high for one cycle, always taken
// config    cfg_we, cfg_index, cfg_data    cfg_we at a rising edge, no wait
//
// Cell write, cursor, visibility, glyph load: done is registered from the execute state.
// Pixel: the 9-step column and row dividers run in parallel, then the tile and glyph
// stores are read (tile read, cursor glyph read, cell glyph read in turn).
// Clear: all MAX_COLS * MAX_ROWS cells are zeroed, one cell zeroed per cycle.
// After reset the same sweep runs with busy high.
// Results cannot be stalled; one transaction is in flight at a time.
module text_tile_pixel_generator_core
    import ttpg_pkg::*;
#(
    parameter int MAX_COLS    = 64,
    parameter int MAX_ROWS    = 32,
    parameter int GLYPH_ROWS  = 16,
    parameter int GLYPH_COUNT = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_t      item,
    output logic       done,
    output result_t    result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int TILE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int TA_W       = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;

    state_t           state_reg, state_next;
    item_t            item_reg;
    cell_t            cursor_cell_reg;
    logic [5:0]       cursor_col_reg;
    logic [4:0]       cursor_row_reg;
    logic             cursor_on_reg;
    logic [3:0]       tw_reg;
    logic [4:0]       th_reg;
    logic [6:0]       cols_reg;
    logic [5:0]       rows_reg;
    cell_t            cell_reg;
    logic [7:0]       crow_reg;
    logic             chit_reg;
    logic             thit_reg;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    logic             accept;
    logic             sweep_busy;
    logic             clear_start;
    logic             div_start;
    logic             tile_we;
    logic             tile_re;
    logic [TA_W-1:0]  tile_waddr;
    logic [TA_W-1:0]  tile_raddr;
    cell_t            tile_wdata;
    cell_t            tile_rdata;
    glyph_wr_t        glyph_wr;
    logic             glyph_re;
    logic [7:0]       query_char;
    logic             glyph_hit;
    logic [7:0]       glyph_rdata;
    logic             cursor_set;
    logic             cursor_vis;

    logic [DIV_W-1:0] w_eff;
    logic [DIV_W-1:0] h_eff;
    logic [PIX_W-1:0] tx;
    logic [PIX_W-1:0] ty;
    logic [DIV_W-1:0] rem_x;
    logic [DIV_W-1:0] rem_y;
    logic             x_done;
    logic             y_done;
    logic [2:0]       lx;
    logic             wr_in_grid;
    logic             pix_in_grid;
    logic             cursor_here;
    logic             cbit;
    logic             tbit;
    logic             cur_draw;
    logic             txt_draw;

    function automatic logic [7:0] pick_color(input cell_t c, input logic bit_set);
        return (bit_set ^ c.invert) ? c.fg_color : c.bg_color;
    endfunction

    // Effective tile size and grid checks
    always_comb
    begin
        if (tw_reg == '0)
            w_eff = DIV_W'(1);
        else if (tw_reg > 4'd8)
            w_eff = DIV_W'(8);
        else
            w_eff = DIV_W'(tw_reg);

        if (th_reg == '0)
            h_eff = DIV_W'(1);
        else if (32'(th_reg) > GLYPH_ROWS)
            h_eff = DIV_W'(GLYPH_ROWS);
        else
            h_eff = DIV_W'(th_reg);

        wr_in_grid = (32'(item_reg.tile_col) < MAX_COLS)
                     && ({1'b0, item_reg.tile_col} < cols_reg)
                     && (32'(item_reg.row_index) < MAX_ROWS)
                     && ({1'b0, item_reg.row_index} < rows_reg);
        pix_in_grid = (32'(tx) < MAX_COLS) && (tx < PIX_W'(cols_reg))
                      && (32'(ty) < MAX_ROWS) && (ty < PIX_W'(rows_reg));
        cursor_here = cursor_on_reg && (tx == PIX_W'(cursor_col_reg))
                      && (ty == PIX_W'(cursor_row_reg));

        tile_waddr = TA_W'(item_reg.row_index) * TA_W'(MAX_COLS)
                     + TA_W'(item_reg.tile_col);
        tile_raddr = TA_W'(ty) * TA_W'(MAX_COLS) + TA_W'(tx);
        tile_wdata = '{char_code:   item_reg.char_code,
                       fg_color:    item_reg.fg_color,
                       bg_color:    item_reg.bg_color,
                       invert:      item_reg.invert,
                       transparent: item_reg.transparent};

        lx   = rem_x[2:0];
        cbit = crow_reg[3'(LEFT_BIT - lx)];
        tbit = glyph_rdata[3'(LEFT_BIT - lx)];
        cur_draw = cursor_here && chit_reg && (cbit || !cursor_cell_reg.transparent);
        txt_draw = pix_in_grid && (cell_reg.char_code != '0) && thit_reg
                   && (tbit || !cell_reg.transparent);
    end

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE) || sweep_busy;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (item.action == ACT_PIXEL)
                        state_next = S_DIV;
                    else if (item.action == ACT_CLEAR)
                        state_next = S_CLEAR;
                    else
                        state_next = S_EXEC;
                end
            end
            S_EXEC:    state_next = S_IDLE;
            S_CLEAR:   state_next = sweep_busy ? S_CLEAR : S_IDLE;
            S_DIV:     state_next = (x_done && y_done) ? S_TILE : S_DIV;
            S_TILE:    state_next = S_GLYPH_C;
            S_GLYPH_C: state_next = S_GLYPH_T;
            S_GLYPH_T: state_next = S_EVAL;
            S_EVAL:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        clear_start = 1'b0;
        div_start   = 1'b0;
        tile_we     = 1'b0;
        tile_re     = 1'b0;
        glyph_re    = 1'b0;
        query_char  = cursor_cell_reg.char_code;
        cursor_set  = 1'b0;
        cursor_vis  = 1'b0;
        done_next   = 1'b0;
        result_next = '0;
        glyph_wr    = '{we:         1'b0,
                        char_code:  item_reg.char_code,
                        row_index:  item_reg.row_index,
                        glyph_bits: item_reg.glyph_bits,
                        flag:       item_reg.flag};
        unique case (state_reg)
            S_IDLE:
            begin
                div_start   = accept && (item.action == ACT_PIXEL);
                clear_start = accept && (item.action == ACT_CLEAR);
            end
            S_EXEC:
            begin
                tile_we     = (item_reg.action == ACT_WRITE_CELL) && wr_in_grid;
                cursor_set  = item_reg.action == ACT_SET_CURSOR;
                cursor_vis  = item_reg.action == ACT_CURSOR_VIS;
                glyph_wr.we = item_reg.action == ACT_LOAD_GLYPH;
                done_next   = 1'b1;
            end
            S_CLEAR:
            begin
                done_next = !sweep_busy;
            end
            S_DIV:
            begin
            end
            S_TILE:
            begin
                tile_re = 1'b1;
            end
            S_GLYPH_C:
            begin
                glyph_re   = 1'b1;
                query_char = cursor_cell_reg.char_code;
            end
            S_GLYPH_T:
            begin
                glyph_re   = 1'b1;
                query_char = cell_reg.char_code;
            end
            S_EVAL:
            begin
                done_next = 1'b1;
                priority if (cur_draw)
                    result_next = '{pixel_write: 1'b1,
                                    pixel_color: pick_color(cursor_cell_reg, cbit)};
                else if (txt_draw)
                    result_next = '{pixel_write: 1'b1,
                                    pixel_color: pick_color(cell_reg, tbit)};
                else
                    result_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            cursor_cell_reg <= '0;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            cursor_on_reg   <= 1'b0;
            tw_reg          <= 4'd8;
            th_reg          <= 5'd16;
            cols_reg        <= 7'd40;
            rows_reg        <= 6'd15;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cursor_set)
            begin
                cursor_cell_reg <= tile_wdata;
                cursor_col_reg  <= item_reg.tile_col;
                cursor_row_reg  <= item_reg.row_index;
            end
            if (cursor_vis)
            begin
                cursor_on_reg <= item_reg.flag;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TILE_WIDTH:  tw_reg   <= cfg_data[3:0];
                    CFG_TILE_HEIGHT: th_reg   <= cfg_data[4:0];
                    CFG_GRID_COLS:   cols_reg <= cfg_data;
                    CFG_GRID_ROWS:   rows_reg <= cfg_data[5:0];
                    default:         tw_reg   <= tw_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == S_GLYPH_C)
        begin
            cell_reg <= tile_rdata;
            chit_reg <= glyph_hit;
        end
        if (state_reg == S_GLYPH_T)
        begin
            crow_reg <= glyph_rdata;
            thit_reg <= glyph_hit;
        end
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    ttpg_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (item.pixel_x),
        .divisor   (w_eff),
        .quotient  (tx),
        .remainder (rem_x),
        .done      (x_done)
    );

    ttpg_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (item.pixel_y),
        .divisor   (h_eff),
        .quotient  (ty),
        .remainder (rem_y),
        .done      (y_done)
    );

    ttpg_tile_ram #(
        .DEPTH (TILE_DEPTH),
        .TA_W  (TA_W)
    ) u_tile_ram (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (clear_start),
        .sweep_busy  (sweep_busy),
        .we          (tile_we),
        .waddr       (tile_waddr),
        .wdata       (tile_wdata),
        .re          (tile_re),
        .raddr       (tile_raddr),
        .rdata       (tile_rdata)
    );

    ttpg_glyph_ram #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_glyph_ram (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (glyph_wr),
        .rd_en      (glyph_re),
        .query_char (query_char),
        .query_row  (rem_y[4:0]),
        .hit        (glyph_hit),
        .rd_data    (glyph_rdata)
    );

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_CLEAR
                      || $past(state_reg) == S_EVAL))
        else $error("result strobe without a finishing transaction");

    a_nonpixel_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && $past(state_reg) != S_EVAL) |-> !result_reg.pixel_write)
        else $error("non-pixel transaction reported a pixel write");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        x_done == y_done)
        else $error("column and row dividers out of step");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept)
        else $error("transaction accepted while another is in flight");

endmodule
